>>> hw/rtl/cdt_pkg.sv
// shared constants, codes, payload and control types of the countdown timer table
package cdt_pkg;

  localparam int TIMER_SLOTS = 16;
  localparam int MAX_RESULTS = 16;

  localparam int IDX_W     = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CNT_W     = $clog2(TIMER_SLOTS + 1);
  localparam int RES_IDX_W = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
  localparam int RES_CNT_W = $clog2(MAX_RESULTS + 1);

  localparam int DUR_W = 22;
  localparam int SUM_W = 24;
  localparam logic [DUR_W-1:0] DUR_MAX = '1;

  localparam int SEC_PER_MIN  = 60;
  localparam int SEC_PER_HOUR = 3600;
  localparam int SEC_PER_DAY  = 86400;

  // divide by reciprocal: 86400 = 675 << 7, 3600 = 225 << 4, 60 = 15 << 2
  // each reciprocal is 2^shift / odd factor rounded up, exact over its range
  localparam int DAY_PRE    = 7;
  localparam int DAY_RECIP  = 49711;
  localparam int DAY_SHIFT  = 25;
  localparam int HOUR_PRE   = 4;
  localparam int HOUR_RECIP = 9321;
  localparam int HOUR_SHIFT = 21;
  localparam int MIN_PRE    = 2;
  localparam int MIN_RECIP  = 1093;
  localparam int MIN_SHIFT  = 14;

  localparam int DIV_STEPS = 6;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [DIV_CNT_W-1:0] DIV_DAY_Q  = DIV_CNT_W'(0);
  localparam logic [DIV_CNT_W-1:0] DIV_DAY_R  = DIV_CNT_W'(1);
  localparam logic [DIV_CNT_W-1:0] DIV_HOUR_Q = DIV_CNT_W'(2);
  localparam logic [DIV_CNT_W-1:0] DIV_HOUR_R = DIV_CNT_W'(3);
  localparam logic [DIV_CNT_W-1:0] DIV_MIN_Q  = DIV_CNT_W'(4);
  localparam logic [DIV_CNT_W-1:0] DIV_MIN_R  = DIV_CNT_W'(5);

  localparam logic [2:0] ACT_START = 3'd0;
  localparam logic [2:0] ACT_STOP  = 3'd1;
  localparam logic [2:0] ACT_TICK  = 3'd2;
  localparam logic [2:0] ACT_QUERY = 3'd3;
  localparam logic [2:0] ACT_CLEAR = 3'd4;

  localparam logic [1:0] KIND_STATUS  = 2'd0;
  localparam logic [1:0] KIND_EXPIRED = 2'd1;
  localparam logic [1:0] KIND_QUERY   = 2'd2;

  localparam logic [1:0] STAT_DONE     = 2'd0;
  localparam logic [1:0] STAT_CONFLICT = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;
  localparam logic [1:0] STAT_NO_NAME  = 2'd3;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  timer_id;
    logic [5:0]  dur_seconds;
    logic [5:0]  dur_minutes;
    logic [4:0]  dur_hours;
    logic [5:0]  dur_days;
    logic        has_name;
    logic [31:0] now_seconds;
    logic [5:0]  query_slot;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] status;
    logic [7:0] out_id;
    logic       is_expired;
    logic [5:0] left_days;
    logic [4:0] left_hours;
    logic [5:0] left_minutes;
    logic [5:0] left_seconds;
    logic [6:0] active_count;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [7:0]       id;
    logic [DUR_W-1:0] dur;
    logic [31:0]      start;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_CLEAR,
    S_QREAD,
    S_QCHECK,
    S_DIVIDE,
    S_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic scan;
    logic commit;
    logic clear;
    logic qread;
    logic qcheck;
    logic div_step;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] act;
    logic       scan_done;
    logic       no_result;
    logic       q_live;
    logic       div_done;
    logic       out_free;
    logic       emit_last;
  } dp_status_t;

endpackage

>>> hw/rtl/countdown_timer_table_unit.sv
// top level of the countdown timer table: controller plus datapath
//
//   channel  ports                          direction  transaction when
//   input    in_valid, in_stall, in_data    in         in_valid && !in_stall
//   result   out_valid, out_stall, out_data out        out_valid && !out_stall
//
// start, stop and tick scan every occupied slot and then emit their results; a tick
// that expires nothing emits no result. the table memory's single read port walks one
// slot a cycle. query reads and checks the slot and, for a live timer, runs the six-step
// days/hours/minutes unit before it emits. clear empties the table. reset (rst_n low,
// synchronous) empties the table.
// a waiting result in the output register does not hold off the next input
// transaction; results of that item wait in the controller until it frees.
module countdown_timer_table_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cdt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cdt_pkg::out_item_t out_data
);

  cdt_pkg::dp_cmd_t    cmd;
  cdt_pkg::dp_status_t st;

  cdt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .st       (st),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  cdt_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

>>> hw/rtl/cdt_ctrl.sv
// sequencing state machine of the countdown timer table
module cdt_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  cdt_pkg::dp_status_t  st,
  output cdt_pkg::dp_cmd_t     cmd,
  output logic                 in_stall
);

  cdt_pkg::ctrl_state_t state_r;
  cdt_pkg::ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cdt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cdt_pkg::S_IDLE: begin
        if (in_valid) state_nxt = cdt_pkg::S_DECODE;
      end
      cdt_pkg::S_DECODE: begin
        case (st.act)
          cdt_pkg::ACT_START, cdt_pkg::ACT_STOP, cdt_pkg::ACT_TICK:
            state_nxt = cdt_pkg::S_SCAN;
          cdt_pkg::ACT_QUERY: state_nxt = cdt_pkg::S_QREAD;
          cdt_pkg::ACT_CLEAR: state_nxt = cdt_pkg::S_CLEAR;
          default:            state_nxt = cdt_pkg::S_IDLE;
        endcase
      end
      cdt_pkg::S_SCAN: begin
        if (st.scan_done) begin
          state_nxt = st.no_result ? cdt_pkg::S_IDLE : cdt_pkg::S_EMIT;
        end
      end
      cdt_pkg::S_CLEAR:  state_nxt = cdt_pkg::S_EMIT;
      cdt_pkg::S_QREAD:  state_nxt = cdt_pkg::S_QCHECK;
      cdt_pkg::S_QCHECK: state_nxt = st.q_live ? cdt_pkg::S_DIVIDE : cdt_pkg::S_EMIT;
      cdt_pkg::S_DIVIDE: begin
        if (st.div_done) state_nxt = cdt_pkg::S_EMIT;
      end
      cdt_pkg::S_EMIT: begin
        if (st.out_free && st.emit_last) state_nxt = cdt_pkg::S_IDLE;
      end
      default: state_nxt = cdt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      cdt_pkg::S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      cdt_pkg::S_SCAN: begin
        cmd.scan   = 1'b1;
        cmd.commit = st.scan_done;
      end
      cdt_pkg::S_CLEAR:  cmd.clear    = 1'b1;
      cdt_pkg::S_QREAD:  cmd.qread    = 1'b1;
      cdt_pkg::S_QCHECK: cmd.qcheck   = 1'b1;
      cdt_pkg::S_DIVIDE: cmd.div_step = 1'b1;
      cdt_pkg::S_EMIT:   cmd.emit     = st.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

>>> hw/rtl/cdt_datapath.sv
// timer table memory, scan/compaction, time-left digit unit and result register
module cdt_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cdt_pkg::in_item_t    in_data,
  input  cdt_pkg::dp_cmd_t     cmd,
  output cdt_pkg::dp_status_t  st,
  input  logic                 out_stall,
  output logic                 out_valid,
  output cdt_pkg::out_item_t   out_data
);

  // table memory: one write port, one registered read port
  cdt_pkg::entry_t mem [cdt_pkg::TIMER_SLOTS];
  cdt_pkg::entry_t rdata_r;
  logic [cdt_pkg::IDX_W-1:0] raddr;
  logic                      wen;
  logic [cdt_pkg::IDX_W-1:0] waddr;
  cdt_pkg::entry_t           wdata;

  logic [7:0] res_buf [cdt_pkg::MAX_RESULTS];
  logic       res_wen;

  cdt_pkg::in_item_t item_r, item_nxt;
  logic [cdt_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [cdt_pkg::CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [cdt_pkg::CNT_W-1:0] wr_idx_r, wr_idx_nxt;
  logic chk_vld_r, chk_vld_nxt;
  logic found_r, found_nxt;
  logic [cdt_pkg::RES_CNT_W-1:0] nres_r, nres_nxt;
  logic [cdt_pkg::RES_CNT_W-1:0] emit_idx_r, emit_idx_nxt;
  logic [1:0] status_r, status_nxt;
  logic [cdt_pkg::DUR_W-1:0] dur_r;
  logic [cdt_pkg::SUM_W-1:0] dur_sum;

  logic [7:0] q_id_r, q_id_nxt;
  logic       q_exp_r, q_exp_nxt;
  logic [cdt_pkg::DUR_W-1:0] rem_r, rem_nxt;
  logic [5:0] days_r, days_nxt;
  logic [4:0] hours_r, hours_nxt;
  logic [5:0] mins_r, mins_nxt;
  logic [cdt_pkg::DIV_CNT_W-1:0] step_r, step_nxt;

  cdt_pkg::out_item_t out_r, out_nxt;
  logic out_valid_r, out_valid_nxt;

  logic [31:0] elapsed;
  logic        chk_exp;
  logic        chk_match;
  logic        chk_drop;
  logic        removes;
  logic        start_ok;
  logic        q_hit;
  logic        is_tick;
  logic        is_query;
  logic        emit_last;
  logic [30:0] day_prod;
  logic [26:0] hour_prod;
  logic [20:0] min_prod;

  assign is_tick  = item_r.action == cdt_pkg::ACT_TICK;
  assign is_query = item_r.action == cdt_pkg::ACT_QUERY;
  assign removes  = item_r.action == cdt_pkg::ACT_STOP || is_tick;

  assign elapsed   = item_r.now_seconds - rdata_r.start;
  assign chk_exp   = elapsed >= 32'(rdata_r.dur);
  assign chk_match = rdata_r.id == item_r.timer_id;

  always_comb begin
    case (item_r.action)
      cdt_pkg::ACT_STOP: chk_drop = chk_match && !found_r;
      cdt_pkg::ACT_TICK: chk_drop = chk_exp &&
                                    (nres_r < cdt_pkg::RES_CNT_W'(cdt_pkg::MAX_RESULTS));
      default:           chk_drop = 1'b0;
    endcase
  end

  assign dur_sum = cdt_pkg::SUM_W'(item_r.dur_seconds)
                 + cdt_pkg::SUM_W'(item_r.dur_minutes) * cdt_pkg::SUM_W'(cdt_pkg::SEC_PER_MIN)
                 + cdt_pkg::SUM_W'(item_r.dur_hours) * cdt_pkg::SUM_W'(cdt_pkg::SEC_PER_HOUR)
                 + cdt_pkg::SUM_W'(item_r.dur_days) * cdt_pkg::SUM_W'(cdt_pkg::SEC_PER_DAY);

  assign start_ok = !found_r && (count_r < cdt_pkg::CNT_W'(cdt_pkg::TIMER_SLOTS))
                    && item_r.has_name;

  assign q_hit = {1'b0, item_r.query_slot} < 7'(count_r);

  assign emit_last = is_tick ? ((emit_idx_r + 1'b1) == nres_r) : 1'b1;

  // time-left quotients: reciprocal multiply on the shifted remainder
  // remainder is below a day before hours and below an hour before minutes
  assign day_prod  = 31'(rem_r[cdt_pkg::DUR_W-1:cdt_pkg::DAY_PRE]) * 31'(cdt_pkg::DAY_RECIP);
  assign hour_prod = 27'(rem_r[16:cdt_pkg::HOUR_PRE]) * 27'(cdt_pkg::HOUR_RECIP);
  assign min_prod  = 21'(rem_r[11:cdt_pkg::MIN_PRE]) * 21'(cdt_pkg::MIN_RECIP);

  always_comb begin
    st.act       = item_r.action;
    st.scan_done = (rd_idx_r >= count_r) && !chk_vld_r;
    st.no_result = is_tick && (nres_r == '0);
    st.q_live    = q_hit && !chk_exp;
    st.div_done  = step_r == cdt_pkg::DIV_MIN_R;
    st.out_free  = !out_valid_r || !out_stall;
    st.emit_last = emit_last;
  end

  assign raddr = cmd.qread ? item_r.query_slot[cdt_pkg::IDX_W-1:0]
                           : rd_idx_r[cdt_pkg::IDX_W-1:0];

  always_comb begin
    item_nxt      = item_r;
    count_nxt     = count_r;
    rd_idx_nxt    = rd_idx_r;
    wr_idx_nxt    = wr_idx_r;
    chk_vld_nxt   = chk_vld_r;
    found_nxt     = found_r;
    nres_nxt      = nres_r;
    emit_idx_nxt  = emit_idx_r;
    status_nxt    = status_r;
    q_id_nxt      = q_id_r;
    q_exp_nxt     = q_exp_r;
    rem_nxt       = rem_r;
    days_nxt      = days_r;
    hours_nxt     = hours_r;
    mins_nxt      = mins_r;
    step_nxt      = step_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    wen           = 1'b0;
    waddr         = wr_idx_r[cdt_pkg::IDX_W-1:0];
    wdata         = rdata_r;
    res_wen       = 1'b0;

    if (!out_stall) out_valid_nxt = 1'b0;

    if (cmd.capture) begin
      item_nxt     = in_data;
      rd_idx_nxt   = '0;
      wr_idx_nxt   = '0;
      chk_vld_nxt  = 1'b0;
      found_nxt    = 1'b0;
      nres_nxt     = '0;
      emit_idx_nxt = '0;
    end

    if (cmd.scan) begin
      // read one slot a cycle, handle the slot read in the cycle before
      if (rd_idx_r < count_r) begin
        rd_idx_nxt  = rd_idx_r + 1'b1;
        chk_vld_nxt = 1'b1;
      end else begin
        chk_vld_nxt = 1'b0;
      end
      if (chk_vld_r) begin
        if (chk_match) found_nxt = 1'b1;
        if (chk_drop) begin
          if (is_tick) begin
            res_wen  = 1'b1;
            nres_nxt = nres_r + 1'b1;
          end
        end else if (removes) begin
          wen        = 1'b1;
          wr_idx_nxt = wr_idx_r + 1'b1;
        end
      end
    end

    if (cmd.commit) begin
      case (item_r.action)
        cdt_pkg::ACT_START: begin
          if (found_r) begin
            status_nxt = cdt_pkg::STAT_CONFLICT;
          end else if (count_r >= cdt_pkg::CNT_W'(cdt_pkg::TIMER_SLOTS)) begin
            status_nxt = cdt_pkg::STAT_FULL;
          end else if (!item_r.has_name) begin
            status_nxt = cdt_pkg::STAT_NO_NAME;
          end else begin
            status_nxt = cdt_pkg::STAT_DONE;
          end
          if (start_ok) begin
            wen         = 1'b1;
            waddr       = count_r[cdt_pkg::IDX_W-1:0];
            wdata.id    = item_r.timer_id;
            wdata.dur   = dur_r;
            wdata.start = item_r.now_seconds;
            count_nxt   = count_r + 1'b1;
          end
        end
        cdt_pkg::ACT_STOP: begin
          status_nxt = found_r ? cdt_pkg::STAT_DONE : cdt_pkg::STAT_CONFLICT;
          count_nxt  = wr_idx_r;
        end
        cdt_pkg::ACT_TICK: count_nxt = wr_idx_r;
        default: count_nxt = count_r;
      endcase
    end

    if (cmd.clear) begin
      count_nxt  = '0;
      status_nxt = cdt_pkg::STAT_DONE;
    end

    if (cmd.qcheck) begin
      q_id_nxt  = q_hit ? rdata_r.id : 8'd0;
      q_exp_nxt = !(q_hit && !chk_exp);
      rem_nxt   = (q_hit && !chk_exp) ? (rdata_r.dur - elapsed[cdt_pkg::DUR_W-1:0]) : '0;
      days_nxt  = '0;
      hours_nxt = '0;
      mins_nxt  = '0;
      step_nxt  = '0;
    end

    // one quotient or one subtract-back per step
    if (cmd.div_step) begin
      step_nxt = step_r + 1'b1;
      case (step_r)
        cdt_pkg::DIV_DAY_Q: begin
          days_nxt = day_prod[cdt_pkg::DAY_SHIFT+5:cdt_pkg::DAY_SHIFT];
        end
        cdt_pkg::DIV_DAY_R: begin
          rem_nxt = rem_r - cdt_pkg::DUR_W'(days_r) * cdt_pkg::DUR_W'(cdt_pkg::SEC_PER_DAY);
        end
        cdt_pkg::DIV_HOUR_Q: begin
          hours_nxt = hour_prod[cdt_pkg::HOUR_SHIFT+4:cdt_pkg::HOUR_SHIFT];
        end
        cdt_pkg::DIV_HOUR_R: begin
          rem_nxt = rem_r - cdt_pkg::DUR_W'(hours_r) * cdt_pkg::DUR_W'(cdt_pkg::SEC_PER_HOUR);
        end
        cdt_pkg::DIV_MIN_Q: begin
          mins_nxt = min_prod[cdt_pkg::MIN_SHIFT+5:cdt_pkg::MIN_SHIFT];
        end
        cdt_pkg::DIV_MIN_R: begin
          rem_nxt = rem_r - cdt_pkg::DUR_W'(mins_r) * cdt_pkg::DUR_W'(cdt_pkg::SEC_PER_MIN);
        end
        default: rem_nxt = rem_r;
      endcase
    end

    if (cmd.emit) begin
      out_valid_nxt        = 1'b1;
      emit_idx_nxt         = emit_idx_r + 1'b1;
      out_nxt.kind         = is_tick ? cdt_pkg::KIND_EXPIRED
                           : (is_query ? cdt_pkg::KIND_QUERY : cdt_pkg::KIND_STATUS);
      out_nxt.status       = (is_tick || is_query) ? cdt_pkg::STAT_DONE : status_r;
      out_nxt.out_id       = is_tick ? res_buf[emit_idx_r[cdt_pkg::RES_IDX_W-1:0]]
                           : (is_query ? q_id_r : 8'd0);
      out_nxt.is_expired   = is_query && q_exp_r;
      out_nxt.left_days    = is_query ? days_r : 6'd0;
      out_nxt.left_hours   = is_query ? hours_r : 5'd0;
      out_nxt.left_minutes = is_query ? mins_r : 6'd0;
      out_nxt.left_seconds = is_query ? rem_r[5:0] : 6'd0;
      out_nxt.active_count = 7'(count_r);
      out_nxt.last         = emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (res_wen) res_buf[nres_r[cdt_pkg::RES_IDX_W-1:0]] <= rdata_r.id;
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    rd_idx_r   <= rd_idx_nxt;
    wr_idx_r   <= wr_idx_nxt;
    found_r    <= found_nxt;
    nres_r     <= nres_nxt;
    emit_idx_r <= emit_idx_nxt;
    status_r   <= status_nxt;
    dur_r      <= (dur_sum > cdt_pkg::SUM_W'(cdt_pkg::DUR_MAX))
                  ? cdt_pkg::DUR_MAX : dur_sum[cdt_pkg::DUR_W-1:0];
    q_id_r     <= q_id_nxt;
    q_exp_r    <= q_exp_nxt;
    rem_r      <= rem_nxt;
    days_r     <= days_nxt;
    hours_r    <= hours_nxt;
    mins_r     <= mins_nxt;
    step_r     <= step_nxt;
    out_r      <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
